// ===== rtl/frbr_pkg.sv =====
package frbr_pkg;

  localparam int W     = 64;
  localparam int CNT_W = $clog2(W);
  localparam int CFG_W = 2;
  localparam int RW    = 32;

  typedef enum logic [CFG_W-1:0] {
    CFG_OUT_RATE_NUM = 2'd0,
    CFG_OUT_RATE_DEN = 2'd1
  } cfg_idx_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic         start;
    logic         mul;
    logic [W-1:0] a;   // dividend or multiplier
    logic [W-1:0] b;   // divisor or multiplicand
  } md_req_t;

  typedef struct packed {
    logic         done;
    logic         ovf;
    logic [W-1:0] quo;
    logic [W-1:0] rem;  // remainder, or product
  } md_rsp_t;

endpackage

// ===== rtl/frame_rate_boundary_rescale.sv =====
// Converts a source frame index to the output rate, floor(frame * out_num * src_den /
// (out_den * src_num)), exact in 64 bits after cancelling common factors by gcd. A word
// is taken when start is high and busy low; for valid arguments busy then stays high until
// the result. The result is shown for exactly one cycle with out_strobe and cannot be
// stalled, so the receiver must take it then. Invalid arguments give the result in the
// cycle after start. Otherwise the work runs through one shared 64-step multiply/divide
// unit: one divide per Euclid step, two divides to cancel a common factor above one,
// then five multiplies and the final divide. The time a word takes is set by the number
// of Euclid steps.
module frame_rate_boundary_rescale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [frbr_pkg::W-1:0]     in_src_frame,
  input  logic [frbr_pkg::W-1:0]     in_src_rate_num,
  input  logic [frbr_pkg::W-1:0]     in_src_rate_den,
  output logic                       out_strobe,
  output logic [frbr_pkg::W-2:0]     out_boundary,
  output logic                       out_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frbr_pkg::CFG_W-1:0] cfg_index,
  input  logic [frbr_pkg::RW-1:0]    cfg_data
);
  import frbr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_GCD  = 10'b0000000010,
    S_GDIV = 10'b0000000100,
    S_RFW  = 10'b0000001000,
    S_RDW  = 10'b0000010000,
    S_NEXT = 10'b0000100000,
    S_MLD  = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_QLD  = 10'b0100000000,
    S_QUO  = 10'b1000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [RW-1:0]  orn_r, ord_r;
  logic [W-1:0]   fac_r [3];
  logic [W-1:0]   fac_nxt [3];
  logic [W-1:0]   dv_r [2];
  logic [W-1:0]   dv_nxt [2];
  logic [W-1:0]   ga_r, ga_nxt, gb_r, gb_nxt;
  logic [W-1:0]   num_r, num_nxt, den_r, den_nxt;
  logic [1:0]     f_r, f_nxt, fn;
  logic           d_r, d_nxt, dn;
  logic [2:0]     mi_r, mi_nxt;
  logic           ostb_r, ostb_nxt, oerr_r, oerr_nxt;
  logic [W-2:0]   ofr_r, ofr_nxt;
  md_req_t        req_r, req_nxt;
  md_rsp_t        rsp;
  logic           bad;
  logic [W-1:0]   g, mfac;

  frbr_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orn_r <= RW'(30);
      ord_r <= RW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OUT_RATE_NUM: orn_r <= cfg_data;
        CFG_OUT_RATE_DEN: ord_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bad = in_src_frame[W-1]
             || in_src_rate_num[W-1] || (in_src_rate_num == '0)
             || in_src_rate_den[W-1] || (in_src_rate_den == '0)
             || orn_r[RW-1] || (orn_r == '0)
             || ord_r[RW-1] || (ord_r == '0);

  always_comb begin
    g = (ga_r == '0) ? W'(1) : ga_r;
    if (f_r == 2'd2) begin
      fn = 2'd0;
      dn = 1'b1;
    end else begin
      fn = f_r + 2'd1;
      dn = d_r;
    end
    case (mi_r)
      3'd0:    mfac = fac_r[0];
      3'd1:    mfac = fac_r[1];
      3'd2:    mfac = fac_r[2];
      3'd3:    mfac = dv_r[0];
      default: mfac = dv_r[1];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fac_nxt   = fac_r;
    dv_nxt    = dv_r;
    ga_nxt    = ga_r;
    gb_nxt    = gb_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    f_nxt     = f_r;
    d_nxt     = d_r;
    mi_nxt    = mi_r;
    ostb_nxt  = 1'b0;
    oerr_nxt  = oerr_r;
    ofr_nxt   = ofr_r;
    req_nxt   = req_r;
    req_nxt.start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (bad) begin
            ostb_nxt = 1'b1;
            oerr_nxt = 1'b1;
            ofr_nxt  = '0;
          end else begin
            fac_nxt[0] = in_src_frame;
            fac_nxt[1] = W'(orn_r);
            fac_nxt[2] = in_src_rate_den;
            dv_nxt[0]  = W'(ord_r);
            dv_nxt[1]  = in_src_rate_num;
            f_nxt      = 2'd0;
            d_nxt      = 1'b0;
            ga_nxt     = in_src_frame;
            gb_nxt     = W'(ord_r);
            state_nxt  = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (gb_r == '0) begin
          ga_nxt = g;
          if (g == W'(1)) begin
            state_nxt = S_NEXT;
          end else begin
            req_nxt = '{start: 1'b1, mul: 1'b0, a: fac_r[f_r], b: g};
            state_nxt = S_RFW;
          end
        end else begin
          req_nxt = '{start: 1'b1, mul: 1'b0, a: ga_r, b: gb_r};
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        if (rsp.done) begin
          ga_nxt    = gb_r;
          gb_nxt    = rsp.rem;
          state_nxt = S_GCD;
        end
      end
      S_RFW: begin
        if (rsp.done) begin
          fac_nxt[f_r] = rsp.quo;
          req_nxt = '{start: 1'b1, mul: 1'b0, a: dv_r[d_r], b: ga_r};
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        if (rsp.done) begin
          dv_nxt[d_r] = rsp.quo;
          state_nxt   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (f_r == 2'd2 && d_r) begin
          num_nxt   = W'(1);
          den_nxt   = W'(1);
          mi_nxt    = 3'd0;
          state_nxt = S_MLD;
        end else begin
          f_nxt     = fn;
          d_nxt     = dn;
          ga_nxt    = fac_r[fn];
          gb_nxt    = dv_r[dn];
          state_nxt = S_GCD;
        end
      end
      S_MLD: begin
        req_nxt = '{start: 1'b1, mul: 1'b1, a: mfac,
                    b: (mi_r < 3'd3) ? num_r : den_r};
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (rsp.done) begin
          if (rsp.ovf) begin
            ostb_nxt  = 1'b1;
            oerr_nxt  = 1'b1;
            ofr_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            if (mi_r < 3'd3) begin
              num_nxt = rsp.rem;
            end else begin
              den_nxt = rsp.rem;
            end
            mi_nxt    = mi_r + 3'd1;
            state_nxt = (mi_r == 3'd4) ? S_QLD : S_MLD;
          end
        end
      end
      S_QLD: begin
        req_nxt = '{start: 1'b1, mul: 1'b0, a: num_r, b: den_r};
        state_nxt = S_QUO;
      end
      S_QUO: begin
        if (rsp.done) begin
          ostb_nxt  = 1'b1;
          oerr_nxt  = rsp.quo[W-1];
          ofr_nxt   = rsp.quo[W-1] ? '0 : rsp.quo[W-2:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ostb_r        <= 1'b0;
      req_r.start   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ostb_r        <= ostb_nxt;
      req_r.start   <= req_nxt.start;
    end
    req_r.mul <= req_nxt.mul;
    req_r.a   <= req_nxt.a;
    req_r.b   <= req_nxt.b;
    fac_r     <= fac_nxt;
    dv_r      <= dv_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    f_r       <= f_nxt;
    d_r       <= d_nxt;
    mi_r      <= mi_nxt;
    oerr_r    <= oerr_nxt;
    ofr_r     <= ofr_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = ostb_r;
  assign out_boundary = ofr_r;
  assign out_error    = oerr_r;

endmodule

// ===== rtl/frbr_muldiv.sv =====
module frbr_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  frbr_pkg::md_req_t req,
  output frbr_pkg::md_rsp_t rsp
);
  import frbr_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             mul_r, mul_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     q_r, q_nxt;
  logic [W-1:0]     p_r, p_nxt;

  logic [W:0]       dsh;
  logic [W+2:0]     x, y, s;
  logic             ge;

  always_comb begin
    dsh = {p_r, q_r[W-1]};
    if (mul_r) begin
      x = {3'b0, p_r[W-2:0], 1'b0};
      y = q_r[W-1] ? {3'b0, b_r} : '0;
      s = x + y;
    end else begin
      x = {2'b0, dsh};
      y = ~{3'b0, b_r};
      s = x + y + {{(W+2){1'b0}}, 1'b1};
    end
    ge = ~s[W+2];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mul_nxt  = mul_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    q_nxt    = q_r;
    p_nxt    = p_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      mul_nxt  = req.mul;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      b_nxt    = req.b;
      q_nxt    = req.a;
      p_nxt    = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (mul_r) begin
        q_nxt   = {q_r[W-2:0], 1'b0};
        p_nxt   = s[W-1:0];
        ovf_nxt = ovf_r | p_r[W-1] | s[W];
      end else begin
        q_nxt = {q_r[W-2:0], ge};
        p_nxt = ge ? s[W-1:0] : dsh[W-1:0];
      end
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mul_r <= mul_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    p_r   <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = p_r;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import frbr_pkg::*;

  localparam int STALL_LIMIT = 400000;
  localparam int TAIL_CYCLES = 64;

  localparam logic [W-1:0]     I64_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]     I64_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]     U64_MAX = {W{1'b1}};
  localparam logic [RW-1:0]    I32_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0]    I32_MIN = {1'b1, {(RW-1){1'b0}}};
  localparam logic [CFG_W-1:0] CFG_IDX_UNUSED_A = 2'd2;
  localparam logic [CFG_W-1:0] CFG_IDX_UNUSED_B = 2'd3;

  typedef struct packed {
    logic [W-2:0] frame;
    logic         err;
  } rescale_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] idx;
    logic [RW-1:0]    data;
    logic [W-1:0]     frame;
    logic [W-1:0]     snum;
    logic [W-1:0]     sden;
    logic             typed;
    rescale_t         want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [W-1:0]     in_src_frame;
  logic [W-1:0]     in_src_rate_num;
  logic [W-1:0]     in_src_rate_den;
  logic             out_strobe;
  logic [W-2:0]     out_boundary;
  logic             out_error;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_index;
  logic [RW-1:0]    cfg_data;

  logic [RW-1:0] rate_num;
  logic [RW-1:0] rate_den;
  rescale_t      pending_rescales [$];
  int            words_sent;
  int            invalid_seen;
  int            reg_writes;
  int            mismatches;
  int            calm_left;
  int            stall_cycles;

  frame_rate_boundary_rescale dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_src_frame    (in_src_frame),
    .in_src_rate_num (in_src_rate_num),
    .in_src_rate_den (in_src_rate_den),
    .out_strobe      (out_strobe),
    .out_boundary    (out_boundary),
    .out_error       (out_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor(frame * num * sden / (den * snum)) after gcd cancellation
  function automatic rescale_t rescale_frame(logic [W-1:0] frame, logic [W-1:0] snum,
                                             logic [W-1:0] sden);
    logic [W-1:0]   fac [3];
    logic [W-1:0]   dv [2];
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   r;
    logic [W-1:0]   q;
    logic [2*W-1:0] num;
    logic [2*W-1:0] den;
    rescale_t       res;
    res.frame = '0;
    res.err = 1'b1;
    if (frame[W-1] || snum == '0 || snum[W-1] || sden == '0 || sden[W-1] ||
        rate_num == '0 || rate_num[RW-1] || rate_den == '0 || rate_den[RW-1])
      return res;
    fac[0] = frame;
    fac[1] = {{(W-RW){1'b0}}, rate_num};
    fac[2] = sden;
    dv[0] = {{(W-RW){1'b0}}, rate_den};
    dv[1] = snum;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = fac[j];
        b = dv[i];
        while (b != '0) begin
          r = a % b;
          a = b;
          b = r;
        end
        if (a == '0) a = W'(1);
        fac[j] = fac[j] / a;
        dv[i] = dv[i] / a;
      end
    end
    num = (2*W)'(1);
    for (int j = 0; j < 3; j++) begin
      num = {{W{1'b0}}, num[W-1:0]} * {{W{1'b0}}, fac[j]};
      if (num[2*W-1:W] != '0) return res;
    end
    den = (2*W)'(1);
    for (int i = 0; i < 2; i++) begin
      den = {{W{1'b0}}, den[W-1:0]} * {{W{1'b0}}, dv[i]};
      if (den[2*W-1:W] != '0 || den == '0) return res;
    end
    q = num[W-1:0] / den[W-1:0];
    if (q[W-1]) return res;
    res.frame = q[W-2:0];
    res.err = 1'b0;
    return res;
  endfunction

  function automatic plan_row_t word_row(logic [W-1:0] f, logic [W-1:0] n, logic [W-1:0] d);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.frame = f;
    row.snum = n;
    row.sden = d;
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [W-1:0] f, logic [W-1:0] n,
                                            logic [W-1:0] d, logic [W-2:0] ef, logic ee);
    plan_row_t row;
    row = word_row(f, n, d);
    row.typed = 1'b1;
    row.want.frame = ef;
    row.want.err = ee;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_W-1:0] idx, logic [RW-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // sender gaps, with calm stretches of back-to-back words
  task automatic draw_gap(output int gap);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(6, 20);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
    end
  endtask

  task automatic send_word(input logic [W-1:0] f, input logic [W-1:0] n,
                           input logic [W-1:0] d, input logic typed, input rescale_t want);
    int gap;
    draw_gap(gap);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_src_frame <= f;
    in_src_rate_num <= n;
    in_src_rate_den <= d;
    do @(posedge clk); while (busy);
    pending_rescales.push_back(typed ? want : rescale_frame(f, n, d));
    words_sent++;
  endtask

  // registers change only once every word in flight has come back
  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [RW-1:0] data);
    start <= 1'b0;
    while (pending_rescales.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_OUT_RATE_NUM) rate_num = data;
    else if (idx == CFG_OUT_RATE_DEN) rate_den = data;
    reg_writes++;
  endtask

  task automatic random_word(output logic [W-1:0] f, output logic [W-1:0] n,
                             output logic [W-1:0] d);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    f = {$urandom, $urandom};
    n = {$urandom, $urandom};
    d = {$urandom, $urandom};
    if (pick < 55) begin
      f = f >> $urandom_range(24, 63);
      case ($urandom_range(0, 7))
        0: begin n = 24000; d = 1001; end
        1: begin n = 30000; d = 1001; end
        2: begin n = 60000; d = 1001; end
        3: begin n = 25; d = 1; end
        4: begin n = 50; d = 1; end
        5: begin n = 24; d = 1; end
        6: begin n = 48000; d = 1; end
        default: begin
          n = $urandom_range(1, 120000);
          d = $urandom_range(1, 1001);
        end
      endcase
    end else if (pick < 70) begin
      f = f >> $urandom_range(24, 63);
      n = $urandom_range(1, 1 << 20);
      d = $urandom_range(1, 1 << 20);
    end else if (pick < 80) begin
      // raw words, sign bits included
    end else if (pick < 86) begin
      f[W-1] = 1'b0;
      n[W-1] = 1'b0;
      d[W-1] = 1'b0;
      if (n == '0) n = 1;
      if (d == '0) d = 1;
    end else if (pick < 93) begin
      // push the products towards overflow
      f = {1'b0, f[W-2:0]} >> $urandom_range(0, 8);
      n = $urandom_range(1, 4);
      d = {{(W-32){1'b0}}, d[31:0]};
      if (d == '0) d = 1;
    end else begin
      f = f >> 32;
      n = $urandom_range(1, 1000);
      d = $urandom_range(1, 1000);
      case ($urandom_range(0, 5))
        0: f[W-1] = 1'b1;
        1: n = '0;
        2: n[W-1] = 1'b1;
        3: d = '0;
        4: d[W-1] = 1'b1;
        default: f = '0;
      endcase
    end
  endtask

  always @(posedge clk) begin : check_results
    rescale_t want;
    if (rst_n && out_strobe) begin
      if (pending_rescales.size() == 0) begin
        $error("out_boundary %0d error %0b arrived with no word outstanding",
               out_boundary, out_error);
        mismatches++;
      end else begin
        want = pending_rescales.pop_front();
        if (out_boundary !== want.frame) begin
          $error("out_boundary: expected %0d, got %0d", want.frame, out_boundary);
          mismatches++;
        end
        if (out_error !== want.err) begin
          $error("out_error: expected %0b, got %0b", want.err, out_error);
          mismatches++;
        end
        if (out_error === 1'b1) invalid_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run
    plan_row_t    plan [$];
    logic [W-1:0] f;
    logic [W-1:0] n;
    logic [W-1:0] d;
    logic [RW-1:0] rn;
    logic [RW-1:0] rd;
    rescale_t     none;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_src_frame <= '0;
    in_src_rate_num <= '0;
    in_src_rate_den <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_OUT_RATE_NUM;
    cfg_data <= '0;
    rate_num = 30;
    rate_den = 1;
    none = '0;

    // reset rate 30/1
    plan.push_back(checked_row('0, 1, 1, 63'd0, 1'b0));
    plan.push_back(checked_row(1, 1, 1, 63'd30, 1'b0));
    plan.push_back(checked_row(100, 25, 1, 63'd120, 1'b0));
    plan.push_back(word_row(1001, 30000, 1001));
    plan.push_back(checked_row(U64_MAX, 1, 1, '0, 1'b1));
    plan.push_back(checked_row(I64_MIN, 1, 1, '0, 1'b1));
    plan.push_back(checked_row(5, '0, 1, '0, 1'b1));
    plan.push_back(checked_row(5, I64_MIN, 1, '0, 1'b1));
    plan.push_back(checked_row(5, 1, '0, '0, 1'b1));
    plan.push_back(checked_row(5, 1, U64_MAX, '0, 1'b1));
    plan.push_back(checked_row(I64_MAX, 1, 1, '0, 1'b1));
    plan.push_back(checked_row(64'h0800_0000_0000_0000, 1, 1, '0, 1'b1));
    plan.push_back(checked_row(I64_MAX, I64_MAX, 1, 63'd30, 1'b0));
    plan.push_back(checked_row(I64_MAX, 30, 1, I64_MAX[W-2:0], 1'b0));
    plan.push_back(checked_row(1, I64_MAX, I64_MAX, 63'd30, 1'b0));
    plan.push_back(checked_row(I64_MAX, 1, I64_MAX, '0, 1'b1));
    // widest output rate
    plan.push_back(reg_row(CFG_OUT_RATE_NUM, I32_MAX));
    plan.push_back(checked_row(1, 1, 1, {31'd0, I32_MAX}, 1'b0));
    plan.push_back(word_row(64'h0000_0001_0000_0000, 1, 1));
    plan.push_back(reg_row(CFG_OUT_RATE_NUM, 1));
    plan.push_back(reg_row(CFG_OUT_RATE_DEN, I32_MAX));
    plan.push_back(checked_row({32'd0, I32_MAX}, 1, 1, 63'd1, 1'b0));
    plan.push_back(word_row(I64_MAX, 1, 1));
    // non-positive output rate terms
    plan.push_back(reg_row(CFG_OUT_RATE_DEN, '0));
    plan.push_back(checked_row(5, 1, 1, '0, 1'b1));
    plan.push_back(reg_row(CFG_OUT_RATE_DEN, I32_MIN));
    plan.push_back(checked_row(5, 1, 1, '0, 1'b1));
    plan.push_back(reg_row(CFG_OUT_RATE_DEN, 1));
    plan.push_back(reg_row(CFG_OUT_RATE_NUM, '0));
    plan.push_back(checked_row(5, 1, 1, '0, 1'b1));
    plan.push_back(reg_row(CFG_OUT_RATE_NUM, I32_MIN));
    plan.push_back(checked_row(5, 1, 1, '0, 1'b1));
    // writes to unused indexes must not land
    plan.push_back(reg_row(CFG_OUT_RATE_NUM, 30));
    plan.push_back(reg_row(CFG_IDX_UNUSED_B, '0));
    plan.push_back(reg_row(CFG_IDX_UNUSED_A, '1));
    plan.push_back(checked_row(2, 1, 1, 63'd60, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].frame, plan[i].snum, plan[i].sden, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin rn = 30; rd = 1; end
        1: begin rn = 30000; rd = 1001; end
        2: begin rn = I32_MAX; rd = 1; end
        3: begin rn = 1; rd = I32_MAX; end
        4: begin rn = $urandom; rd = $urandom; end
        5: begin rn = 24000; rd = 1001; end
        6: begin rn = '0; rd = 1; end
        7: begin rn = 25; rd = I32_MIN; end
        8: begin rn = $urandom_range(1, 1 << 16); rd = $urandom_range(1, 1 << 16); end
        default: begin rn = 60000; rd = 1001; end
      endcase
      write_reg(CFG_OUT_RATE_NUM, rn);
      write_reg(CFG_OUT_RATE_DEN, rd);
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) == 1 ? CFG_IDX_UNUSED_A : CFG_IDX_UNUSED_B, $urandom);
      repeat (29) begin
        random_word(f, n, d);
        send_word(f, n, d, 1'b0, none);
      end
    end

    start <= 1'b0;
    while (pending_rescales.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("rescaled %0d words (%0d flagged invalid) over 10 random rate settings",
             words_sent, invalid_seen);
    $display("plus directed extremes; %0d register writes, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
